[rtl/interval_average_extremes_logger_assert.svh]
// Assertion macros used by the checker file.
`ifndef INTERVAL_AVERAGE_EXTREMES_LOGGER_ASSERT_SVH
`define INTERVAL_AVERAGE_EXTREMES_LOGGER_ASSERT_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define IAEL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define IAEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/iael_pkg.sv]
package iael_pkg;

  localparam int MeasWidth   = 24;
  localparam int CountWidth  = 24;
  localparam int NumStatus   = 5;
  localparam int SumWidth    = 48;
  localparam int TimeWidth   = 32;
  localparam int StatusWidth = 3;
  localparam int CfgIdxWidth = 3;
  localparam int CfgDatWidth = 32;

  localparam logic [CfgIdxWidth-1:0] CfgWindowStart  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgWindowEnd    = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgAvgInterval  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgStatusMask   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgExtremesOnly = 3'd4;

  localparam logic [1:0] KindAverage  = 2'd0;
  localparam logic [1:0] KindExtremes = 2'd1;
  localparam logic [1:0] KindNoData   = 2'd2;

  localparam logic signed [MeasWidth-1:0] MeasMax = {1'b0, {(MeasWidth-1){1'b1}}};
  localparam logic signed [MeasWidth-1:0] MeasMin = {1'b1, {(MeasWidth-1){1'b0}}};

  typedef struct packed {
    logic                   command;
    logic [TimeWidth-1:0]   timestamp;
    logic signed [MeasWidth-1:0] temp_outside;
    logic signed [MeasWidth-1:0] temp_inside;
    logic signed [MeasWidth-1:0] temp_mirror;
    logic signed [MeasWidth-1:0] wind_vel;
    logic signed [MeasWidth-1:0] pressure;
    logic signed [MeasWidth-1:0] humidity;
    logic [StatusWidth-1:0] record_status;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [TimeWidth-1:0]   mid_time;
    logic [1:0]             channel;
    logic signed [MeasWidth-1:0] value_a;
    logic signed [MeasWidth-1:0] value_b;
    logic signed [MeasWidth-1:0] value_c;
    logic signed [MeasWidth-1:0] value_d;
    logic signed [MeasWidth-1:0] value_e;
    logic signed [MeasWidth-1:0] value_f;
    logic [StatusWidth-1:0] majority_status;
    logic                   last;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxWidth-1:0] index;
    logic [CfgDatWidth-1:0] data;
  } cfg_word_t;

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;

endpackage

[rtl/iael_if.sv]
interface iael_in_if (input logic clk_i);
  logic valid;
  logic ready;
  iael_pkg::in_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface iael_out_if (input logic clk_i);
  logic valid;
  logic ready;
  iael_pkg::out_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface iael_cfg_if (input logic clk_i);
  logic valid;
  logic ready;
  iael_pkg::cfg_word_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

[rtl/interval_average_extremes_logger.sv]
// Sequence: a record that closes an interval is screened, the status votes are compared,
// six averages are divided in turn on one shared divider, and the average word is emitted.
// Other records are only screened; an end word gives its results from the end state, one a cycle
// while the output accepts them. Throughput: one word at a time; a closing record holds the input
// until its divisions on the single shared divider are done. Reset (rst_ni, asynchronous, active low)
// restores the register defaults and clears all run state.
module interval_average_extremes_logger (
  input logic clk_i,
  input logic rst_ni,
  iael_in_if.sink    in_if,
  iael_out_if.source out_if,
  iael_cfg_if.sink   cfg_if
);
  localparam int MW = iael_pkg::MeasWidth;
  localparam int SW = iael_pkg::SumWidth;
  localparam int CW = iael_pkg::CountWidth;
  localparam int NS = iael_pkg::NumStatus;

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StRecord = 7'b0000010,
    StVote   = 7'b0000100,
    StDivGo  = 7'b0001000,
    StDivRun = 7'b0010000,
    StEmit   = 7'b0100000,
    StEnd    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [31:0] win_start_q, win_end_q, avg_int_q;
  logic [4:0] mask_q;
  logic ext_only_q;

  // Run state.
  logic open_q, any_q, stop_q;
  logic [31:0] begin_q, prev_q;
  logic signed [SW-1:0] sums_q [6];
  logic [CW-1:0] count_q;
  logic [CW-1:0] votes_q [NS];
  logic signed [MW-1:0] min_q [4];
  logic signed [MW-1:0] max_q [4];

  // Latched input word and working registers.
  iael_pkg::in_word_t word_q;
  logic [2:0] idx_q;
  logic [2:0] best_q;
  logic [CW-1:0] top_q;
  iael_pkg::out_word_t res_q;
  logic res_valid_q;

  logic signed [MW-1:0] meas [6];
  logic signed [MW-1:0] quo;
  logic div_busy;
  iael_pkg::div_ctrl_t div_ctrl;
  logic signed [SW-1:0] div_num;

  assign meas[0] = word_q.temp_outside;
  assign meas[1] = word_q.temp_inside;
  assign meas[2] = word_q.temp_mirror;
  assign meas[3] = word_q.wind_vel;
  assign meas[4] = word_q.pressure;
  assign meas[5] = word_q.humidity;

  assign div_num = sums_q[idx_q[2:0] > 3'd5 ? 3'd5 : idx_q];
  assign div_ctrl.start = (state_q == StDivGo);
  assign div_ctrl.busy = div_busy;

  iael_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_num),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign in_if.ready = (state_q == StIdle) && !res_valid_q;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = res_valid_q;
  assign out_if.word = res_q;

  logic in_acc, out_acc;
  assign in_acc = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;

  // Record screening, evaluated on the latched word.
  logic st_ok, closes;
  logic signed [32:0] elapsed;
  always_comb begin
    st_ok = (word_q.record_status < 3'(NS)) && mask_q[word_q.record_status];
    elapsed = $signed({1'b0, word_q.timestamp}) - $signed({1'b0, begin_q});
    closes = open_q && (elapsed >= $signed({1'b0, avg_int_q}));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) state_d = in_if.word.command ? StEnd : StRecord;
      end
      StRecord: begin
        if (!stop_q && word_q.timestamp >= win_start_q && word_q.timestamp <= win_end_q
            && st_ok && !ext_only_q && closes) state_d = StVote;
        else state_d = StIdle;
      end
      StVote: begin
        if (idx_q == 3'(NS - 1)) state_d = StDivGo;
      end
      StDivGo: state_d = StDivRun;
      StDivRun: begin
        if (!div_busy) state_d = (idx_q == 3'd5) ? StEmit : StDivGo;
      end
      StEmit: begin
        if (!res_valid_q) state_d = StRecord;
      end
      StEnd: begin
        if (out_acc && (out_if.word.last)) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      win_start_q <= '0;
      win_end_q <= '1;
      avg_int_q <= 32'd1;
      mask_q <= 5'd31;
      ext_only_q <= 1'b0;
      open_q <= 1'b0;
      any_q <= 1'b0;
      stop_q <= 1'b0;
      begin_q <= '0;
      prev_q <= '0;
      count_q <= '0;
      res_valid_q <= 1'b0;
      idx_q <= '0;
      for (int i = 0; i < 6; i++) sums_q[i] <= '0;
      for (int i = 0; i < NS; i++) votes_q[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        min_q[i] <= iael_pkg::MeasMax;
        max_q[i] <= iael_pkg::MeasMin;
      end
    end else begin
      state_q <= state_d;
      if (cfg_if.valid) begin
        unique case (cfg_if.word.index)
          iael_pkg::CfgWindowStart: win_start_q <= cfg_if.word.data;
          iael_pkg::CfgWindowEnd: win_end_q <= cfg_if.word.data;
          iael_pkg::CfgAvgInterval:
            avg_int_q <= (cfg_if.word.data == '0) ? 32'd1 : cfg_if.word.data;
          iael_pkg::CfgStatusMask: mask_q <= cfg_if.word.data[4:0];
          iael_pkg::CfgExtremesOnly: ext_only_q <= cfg_if.word.data[0];
          default: ;
        endcase
      end
      if (out_acc) res_valid_q <= 1'b0;

      unique case (state_q)
        StIdle: idx_q <= '0;
        StRecord: begin
          if (!stop_q && word_q.timestamp >= win_start_q) begin
            if (word_q.timestamp > win_end_q) stop_q <= 1'b1;
            else if (st_ok) begin
              if (!(!ext_only_q && closes)) begin
                // Accept the record: interval bookkeeping then extremes.
                any_q <= 1'b1;
                if (!ext_only_q) begin
                  if (!open_q) begin
                    open_q <= 1'b1;
                    begin_q <= word_q.timestamp;
                  end
                  prev_q <= word_q.timestamp;
                  if (count_q != '1) begin
                    for (int i = 0; i < 6; i++)
                      sums_q[i] <= sums_q[i] + SW'(meas[i]);
                    votes_q[word_q.record_status] <=
                      votes_q[word_q.record_status] + 1'b1;
                    count_q <= count_q + 1'b1;
                  end
                end
                for (int i = 0; i < 4; i++) begin
                  if (meas[i] > max_q[i]) max_q[i] <= meas[i];
                  if (meas[i] < min_q[i]) min_q[i] <= meas[i];
                end
              end
            end
          end
          idx_q <= '0;
        end
        StVote: begin
          // One vote compared per cycle; strict greater keeps the lower code.
          if (idx_q == '0 || votes_q[idx_q] > top_q) begin
            top_q <= votes_q[idx_q];
            best_q <= idx_q;
          end
          if (idx_q == '0 && votes_q[0] == '0) best_q <= '0;
          idx_q <= (idx_q == 3'(NS - 1)) ? '0 : idx_q + 1'b1;
        end
        StDivGo: ;
        StDivRun: begin
          if (!div_busy) begin
            unique case (idx_q)
              3'd0: res_q.value_a <= quo;
              3'd1: res_q.value_b <= quo;
              3'd2: res_q.value_c <= quo;
              3'd3: res_q.value_d <= quo;
              3'd4: res_q.value_e <= quo;
              default: res_q.value_f <= quo;
            endcase
            if (idx_q != 3'd5) idx_q <= idx_q + 1'b1;
          end
        end
        StEmit: begin
          if (!res_valid_q) begin
            res_q.kind <= iael_pkg::KindAverage;
            res_q.mid_time <= {1'b0, begin_q[31:1]} + {1'b0, prev_q[31:1]};
            res_q.channel <= '0;
            res_q.majority_status <= (top_q == '0) ? '0 : best_q;
            res_q.last <= 1'b0;
            res_valid_q <= 1'b1;
            begin_q <= word_q.timestamp;
            for (int i = 0; i < 6; i++) sums_q[i] <= '0;
            for (int i = 0; i < NS; i++) votes_q[i] <= '0;
            count_q <= '0;
            // The closing record is then folded in as an ordinary record.
            open_q <= 1'b1;
          end
        end
        StEnd: begin
          if (!res_valid_q || out_acc) begin
            if (!(out_acc && res_q.last)) begin
              res_valid_q <= 1'b1;
              res_q.mid_time <= '0;
              res_q.value_c <= '0;
              res_q.value_d <= '0;
              res_q.value_e <= '0;
              res_q.value_f <= '0;
              res_q.majority_status <= '0;
              if (!any_q) begin
                res_q.kind <= iael_pkg::KindNoData;
                res_q.channel <= '0;
                res_q.value_a <= '0;
                res_q.value_b <= '0;
                res_q.last <= 1'b1;
              end else begin
                res_q.kind <= iael_pkg::KindExtremes;
                res_q.channel <= idx_q[1:0];
                res_q.value_a <= min_q[idx_q[1:0]];
                res_q.value_b <= max_q[idx_q[1:0]];
                res_q.last <= (idx_q == 3'd3);
                idx_q <= idx_q + 1'b1;
              end
            end else begin
              // Final word taken: return the run state to its reset values.
              open_q <= 1'b0;
              any_q <= 1'b0;
              stop_q <= 1'b0;
              begin_q <= '0;
              prev_q <= '0;
              count_q <= '0;
              for (int i = 0; i < 6; i++) sums_q[i] <= '0;
              for (int i = 0; i < NS; i++) votes_q[i] <= '0;
              for (int i = 0; i < 4; i++) begin
                min_q[i] <= iael_pkg::MeasMax;
                max_q[i] <= iael_pkg::MeasMin;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) word_q <= in_if.word;
  end
endmodule

[rtl/iael_divider.sv]
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module iael_divider (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  iael_pkg::div_ctrl_t                   ctrl_i,
  input  logic signed [iael_pkg::SumWidth-1:0]  dividend_i,
  input  logic [iael_pkg::CountWidth-1:0]       divisor_i,
  output logic                                  busy_o,
  output logic signed [iael_pkg::MeasWidth-1:0] quotient_o
);
  localparam int W = iael_pkg::SumWidth;
  localparam int CntW = $clog2(W + 1);

  logic [W-1:0] quo_q, quo_d;
  logic [W:0] rem_q, rem_d;
  logic [iael_pkg::CountWidth-1:0] den_q, den_d;
  logic neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [W:0] shifted;
  logic [W:0] trial;
  logic [W-1:0] neg_quo;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    shifted = {rem_q[W-1:0], quo_q[W-1]};
    trial = shifted - {{(W + 1 - iael_pkg::CountWidth){1'b0}}, den_q};
    if (ctrl_i.start) begin
      quo_d = dividend_i[W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_d = '0;
      den_d = divisor_i;
      neg_d = dividend_i[W-1];
      cnt_d = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign neg_quo = ~quo_q + 1'b1;
  assign busy_o = busy_q;
  assign quotient_o = neg_q ? neg_quo[iael_pkg::MeasWidth-1:0]
                            : quo_q[iael_pkg::MeasWidth-1:0];
endmodule

[rtl/iael_checker.sv]
`include "interval_average_extremes_logger_assert.svh"

module iael_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [1:0] out_kind,
  input logic [1:0] out_channel
);
  `IAEL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `IAEL_ASSERT_IMP(a_nodata_last, clk_i, rst_ni,
                   out_valid && out_kind == iael_pkg::KindNoData, out_last)
  `IAEL_ASSERT_IMP(a_avg_not_last, clk_i, rst_ni,
                   out_valid && out_kind == iael_pkg::KindAverage, !out_last)
  `IAEL_ASSERT_IMP(a_ext_last, clk_i, rst_ni,
                   out_valid && out_kind == iael_pkg::KindExtremes,
                   out_last == (out_channel == 2'd3))
  `IAEL_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, in_valid && in_ready, !out_valid)
endmodule

bind interval_average_extremes_logger iael_checker u_iael_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_last    (out_if.word.last),
  .out_kind    (out_if.word.kind),
  .out_channel (out_if.word.channel)
);
